[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL; they compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/tdp_pkg.sv]
`timescale 1ns / 1ps
// Shared widths for the trial-division prime test.
package tdp_pkg;

  localparam int NUMBER_WIDTH = 32;
  localparam int CNT_W        = $clog2(NUMBER_WIDTH + 1);

  typedef logic [NUMBER_WIDTH-1:0] num_t;
  typedef logic [CNT_W-1:0]        cnt_t;

endpackage

[hw/rtl/tdp_divider.sv]
`timescale 1ns / 1ps
// Restoring divider that yields one quotient bit per cycle.
module tdp_divider
  import tdp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  num_t dividend,
  input  num_t divisor,
  output logic done,
  output num_t quotient,
  output num_t remainder
);

  num_t quo_r, quo_nxt;
  num_t rem_r, rem_nxt;
  num_t div_r;
  cnt_t cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  logic [NUMBER_WIDTH:0] shifted;
  logic [NUMBER_WIDTH:0] diff;

  always_comb begin
    shifted  = {rem_r, quo_r[NUMBER_WIDTH-1]};
    diff     = shifted - {1'b0, div_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUMBER_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // A clear top bit of the difference means the divisor fits.
      if (!diff[NUMBER_WIDTH]) begin
        rem_nxt = diff[NUMBER_WIDTH-1:0];
        quo_nxt = {quo_r[NUMBER_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[NUMBER_WIDTH-1:0];
        quo_nxt = {quo_r[NUMBER_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[hw/rtl/trial_division_prime_test.sv]
// Trial-division prime test: one signed number in, one result out.
// Negative numbers, zero and one give a result in the cycle after the transfer.
// Otherwise candidate divisors from two upward are tried in turn on the shared divider,
// until one divides the number or the divisor exceeds the quotient.
// busy stays high until the result strobe; the receiver cannot stall.
// Reset (rst_n low, synchronous) returns the sequencer to idle with no result.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trial_division_prime_test
  import tdp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  num_t in_number,
  output logic out_valid,
  output num_t out_tested_number,
  output logic out_is_prime
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state_r, state_nxt;
  num_t num_r, num_nxt;
  num_t d_r, d_nxt;
  logic div_start_r, div_start_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_prime_r, out_prime_nxt;

  logic div_done;
  num_t div_quo;
  num_t div_rem;
  logic trivial;

  tdp_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .dividend  (num_r),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Negative numbers, zero and one are never prime.
  assign trivial = in_number[NUMBER_WIDTH-1] || (in_number[NUMBER_WIDTH-1:1] == '0);

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    d_nxt         = d_r;
    div_start_nxt = 1'b0;
    out_valid_nxt = 1'b0;
    out_prime_nxt = out_prime_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          num_nxt = in_number;
          if (trivial) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
          end else begin
            d_nxt         = NUMBER_WIDTH'(2);
            div_start_nxt = 1'b1;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // Once the divisor exceeds the quotient, no factor is left to try.
          if (d_r > div_quo) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else if (div_rem == '0) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            d_nxt         = d_r + NUMBER_WIDTH'(1);
            div_start_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r       <= num_nxt;
    d_r         <= d_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_tested_number = num_r;
  assign out_is_prime      = out_prime_r;

  `ASSERT_IMPLIES(a_div_start_in_div, clk, rst_n, div_start_r, state_r == ST_DIV)
  `ASSERT_IMPLIES(a_done_in_div, clk, rst_n, div_done, state_r == ST_DIV && !div_start_r)
  `ASSERT_IMPLIES(a_prime_nonneg, clk, rst_n, out_valid_r && out_prime_r,
                  !num_r[NUMBER_WIDTH-1] && d_r > NUMBER_WIDTH'(1))

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the trial-division prime test block.
module testbench;
  import tdp_pkg::*;

  localparam num_t MAX_POSITIVE = {1'b0, {(NUMBER_WIDTH-1){1'b1}}};
  localparam num_t MOST_NEGATIVE = {1'b1, {(NUMBER_WIDTH-1){1'b0}}};
  localparam int RANDOM_ITEMS = 100;
  localparam int IDLE_PERCENT = 14;

  typedef struct packed {
    num_t tested_number;
    logic is_prime;
  } prime_verdict_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  num_t in_number;
  logic out_valid;
  num_t out_tested_number;
  logic out_is_prime;

  prime_verdict_t awaited_verdicts[$];
  int error_count;
  int transfer_count;
  int checked_count;
  int prime_count;
  int negative_count;

  trial_division_prime_test u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_number(in_number),
    .out_valid(out_valid),
    .out_tested_number(out_tested_number),
    .out_is_prime(out_is_prime)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("[trial_division_prime_test] ERROR");
    $finish;
  end

  // The sign bit rules a number out; otherwise divide by every d with d*d <= n.
  function automatic logic prime_by_trial(num_t value);
    longint unsigned n;
    longint unsigned d;
    if (value[NUMBER_WIDTH-1]) return 1'b0;
    n = value;
    if (n < 2) return 1'b0;
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Start stays high until the edge that sees busy low, which is the transfer.
  task automatic send_number(num_t value);
    prime_verdict_t verdict;
    @(negedge clk);
    start = 1'b1;
    in_number = value;
    do @(posedge clk); while (busy);
    verdict.tested_number = value;
    verdict.is_prime = prime_by_trial(value);
    awaited_verdicts.push_back(verdict);
    transfer_count++;
    if (value[NUMBER_WIDTH-1]) negative_count++;
    if (verdict.is_prime) prime_count++;
  endtask

  task automatic hold_off(int cycles);
    @(negedge clk);
    start = 1'b0;
    in_number = num_t'($urandom());
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    prime_verdict_t expected;
    if (rst_n && out_valid) begin
      checked_count++;
      if (awaited_verdicts.size() == 0) begin
        $error("result with no transfer pending: tested_number=%0d is_prime=%0b",
               $signed(out_tested_number), out_is_prime);
        error_count++;
      end else begin
        expected = awaited_verdicts.pop_front();
        if (out_tested_number !== expected.tested_number) begin
          $error("tested_number: expected %0d, actual %0d",
                 $signed(expected.tested_number), $signed(out_tested_number));
          error_count++;
        end
        if (out_is_prime !== expected.is_prime) begin
          $error("is_prime (number %0d): expected %0b, actual %0b",
                 $signed(expected.tested_number), expected.is_prime, out_is_prime);
          error_count++;
        end
      end
    end
  end

  task automatic test_numbers_below_two();
    send_number('0);
    send_number(num_t'(1));
    send_number('1);
    send_number(MOST_NEGATIVE);
    send_number(num_t'(32'hAAAA_AAAA));
  endtask

  // Two and three never enter the divisor loop; squares stop exactly at d*d == n.
  task automatic test_small_boundaries();
    send_number(num_t'(2));
    send_number(num_t'(3));
    send_number(num_t'(4));
    send_number(num_t'(9));
    send_number(num_t'(25));
    send_number(num_t'(49));
    send_number(num_t'(97));
    send_number(num_t'(121));
    send_number(num_t'(65521));
    send_number(num_t'(65537));
    send_number(num_t'(1000003));
    drain_results();
  endtask

  // The largest positive value is prime and walks the whole divisor range.
  task automatic test_positive_extremes();
    send_number(MAX_POSITIVE - 1);
    send_number(MAX_POSITIVE - 2);
    send_number(num_t'(32'h5555_5555));
    send_number(MAX_POSITIVE);
    drain_results();
  endtask

  // Mostly fast cases; large positives are forced to carry a small factor.
  task automatic test_random_mix();
    num_t value;
    int kind;
    int factor;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        value = num_t'($urandom()) | MOST_NEGATIVE;
      end else if (kind <= 5) begin
        value = num_t'($urandom_range(0, 2000));
      end else if (kind <= 7) begin
        value = num_t'($urandom_range(2001, 1 << 18));
      end else begin
        value = num_t'($urandom_range(32'h0010_0000, 32'h7FFF_FFFF));
        case ($urandom_range(0, 3))
          0: factor = 2;
          1: factor = 3;
          2: factor = 5;
          default: factor = 7;
        endcase
        value = value - value % factor;
      end
      send_number(value);
      if (i == RANDOM_ITEMS / 2) begin
        drain_results();
      end else if ((i < 30 || i >= 70) && $urandom_range(0, 99) < IDLE_PERCENT) begin
        hold_off($urandom_range(1, 40));
      end
    end
  endtask

  initial begin
    error_count = 0;
    transfer_count = 0;
    checked_count = 0;
    prime_count = 0;
    negative_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_number = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_numbers_below_two();
    test_small_boundaries();
    test_positive_extremes();
    test_random_mix();

    @(negedge clk);
    start = 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d numbers (%0d negative, %0d prime) and checked %0d results.",
             transfer_count, negative_count, prime_count, checked_count);
    $display("Covered zero, one, two, three, prime squares and both field extremes.");
    if (error_count == 0 && awaited_verdicts.size() == 0) begin
      $display("[trial_division_prime_test] OK");
    end else begin
      $display("[trial_division_prime_test] ERROR");
    end
    $finish;
  end

endmodule

[trial_division_prime_test.f]
+incdir+hw/rtl
hw/rtl/tdp_pkg.sv
hw/rtl/tdp_divider.sv
hw/rtl/trial_division_prime_test.sv
tb/testbench.sv
